>>> rtl/asfb_pkg.sv
`timescale 1ns / 1ps

package asfb_pkg;

    // Number of past scaled samples kept for the FIR and moving average
    localparam int Taps = 4;

    // Samples per burst after reset
    localparam logic [7:0] BurstLenReset = 8'd100;

    // Reciprocals: floor(x * R >> S) equals floor(x / D) over the ranges used here
    localparam logic [10:0] Recip25 = 11'd1311;  // (raw / 16) / 25, shift 15
    localparam logic [7:0]  Recip3  = 8'd171;    // sum of 3 taps / 3, shift 9
    localparam logic [7:0]  Recip5  = 8'd205;    // IIR sum / 5, shift 10

    typedef struct packed {
        logic signed [15:0] raw_accel_z;
        logic               restart;
    } t_in;

    typedef struct packed {
        logic        [7:0] sample_number;
        logic signed [7:0] scaled_z;
        logic signed [7:0] moving_average;
        logic signed [7:0] iir_output;
        logic signed [7:0] fir_output;
    } t_out;

    // trunc(-raw / 400): divide the magnitude by 16, then by 25 via reciprocal
    function automatic logic signed [7:0] f_scale(input logic signed [15:0] raw);
        logic [15:0] mag;
        logic [11:0] x;
        logic [22:0] p;
        logic [6:0]  q;
        mag = raw[15] ? 16'(~unsigned'(raw) + 16'd1) : unsigned'(raw);
        x   = mag[15:4];
        p   = 23'(x) * 23'(Recip25);
        q   = 7'(p >> 15);
        // a negative raw sample gives a positive result
        return raw[15] ? $signed({1'b0, q}) : -$signed({1'b0, q});
    endfunction

    // Signed division by 3, truncated toward zero
    function automatic logic signed [7:0] f_div3(input logic signed [8:0] s);
        logic [8:0]  mag;
        logic [17:0] p;
        logic [6:0]  q;
        mag = s[8] ? 9'(~unsigned'(s) + 9'd1) : unsigned'(s);
        p   = 18'(mag) * 18'(Recip3);
        q   = 7'(p >> 9);
        return s[8] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Signed division by 5, truncated toward zero
    function automatic logic signed [7:0] f_div5(input logic signed [9:0] s);
        logic [9:0]  mag;
        logic [19:0] p;
        logic [6:0]  q;
        mag = s[9] ? 10'(~unsigned'(s) + 10'd1) : unsigned'(s);
        p   = 20'(mag) * 20'(Recip5);
        q   = 7'(p >> 10);
        return s[9] ? -$signed({1'b0, q}) : $signed({1'b0, q});
    endfunction

    // Signed division by 8, truncated toward zero
    function automatic logic signed [7:0] f_div8(input logic signed [10:0] s);
        logic signed [10:0] b;
        b = s + (s[10] ? 11'sd7 : 11'sd0);
        return 8'(b >>> 3);
    endfunction

endpackage

>>> rtl/accel_sample_filter_bank.sv
`timescale 1ns / 1ps

// Smoothing filter bank for accelerometer Z samples. A beat with restart set
// opens a burst of burst_length samples (the restart beat is sample 1); outside
// a burst, input beats are absorbed with no result. Each burst sample yields one
// result beat: sample number, z = trunc(-raw/400), a 3-tap moving average, a
// first-order IIR (4*prev+z)/5 and a 1,2,2,2,1 / 8 FIR, all truncated toward
// zero. The block takes one beat per cycle unless stalled: a beat is held in
// the input register, its filters are evaluated against the history in a
// single pass, and the result is held in the result register, which presents
// the result beat. Input stall follows output stall while both registers are
// full. Write burst_length only while no beat is in flight.

module accel_sample_filter_bank
    import asfb_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out
);

    logic              r_in_valid;
    t_in               r_in;
    logic              r_out_valid;
    t_out              r_out;
    logic [7:0]        r_burst_len;
    logic signed [7:0] r_dly [Taps];
    logic signed [7:0] r_prev_iir;
    logic [7:0]        r_count;
    logic              r_active;

    logic              w_adv;
    logic              w_take;
    logic              w_active;
    logic [7:0]        w_count;
    logic signed [7:0] w_z;
    logic signed [7:0] w_d0;
    logic signed [7:0] w_d1;
    logic signed [7:0] w_d2;
    logic signed [7:0] w_d3;
    logic signed [7:0] w_prev;
    logic signed [8:0] w_sum3;
    logic signed [9:0] w_sum_iir;
    logic signed [10:0] w_sum_fir;
    t_out              n_out;

    // Advance when the result register is empty or being taken
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_take     = r_in_valid && w_adv;

    // Restart clears history before this sample is used
    assign w_active = r_in.restart || r_active;
    assign w_count  = (r_in.restart ? 8'd0 : r_count) + 8'd1;
    assign w_d0     = r_in.restart ? 8'sd0 : r_dly[0];
    assign w_d1     = r_in.restart ? 8'sd0 : r_dly[1];
    assign w_d2     = r_in.restart ? 8'sd0 : r_dly[2];
    assign w_d3     = r_in.restart ? 8'sd0 : r_dly[3];
    assign w_prev   = r_in.restart ? 8'sd0 : r_prev_iir;

    // Filter arithmetic on the current sample and history
    assign w_z       = f_scale(r_in.raw_accel_z);
    assign w_sum3    = 9'(w_z) + 9'(w_d0) + 9'(w_d1);
    assign w_sum_iir = $signed({w_prev, 2'b00}) + 10'(w_z);
    assign w_sum_fir = 11'(w_d3) + 11'(w_z) + ((11'(w_d0) + 11'(w_d1) + 11'(w_d2)) <<< 1);

    always_comb begin
        n_out.sample_number  = w_count;
        n_out.scaled_z       = w_z;
        n_out.moving_average = (w_count >= 8'd3) ? f_div3(w_sum3) : w_z;
        n_out.iir_output     = (w_count == 8'd1) ? w_z : f_div5(w_sum_iir);
        n_out.fir_output     = (w_count >= 8'd5) ? f_div8(w_sum_fir) : w_z;
    end

    // Input register: load on accept, drop once consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Result register: present one beat per burst sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_take && w_active;
        end
        if (w_take && w_active) begin
            r_out <= n_out;
        end
    end

    // Filter history and burst control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_burst_len <= BurstLenReset;
            r_prev_iir  <= 8'sd0;
            r_count     <= 8'd0;
            r_active    <= 1'b0;
            for (int i = 0; i < Taps; i++) begin
                r_dly[i] <= 8'sd0;
            end
        end else begin
            if (i_cfg_we) begin
                r_burst_len <= i_cfg_wdata;
            end
            if (w_take && w_active) begin
                r_count    <= w_count;
                r_prev_iir <= n_out.iir_output;
                r_dly[0]   <= w_z;
                r_dly[1]   <= w_d0;
                r_dly[2]   <= w_d1;
                r_dly[3]   <= w_d2;
                r_active   <= (w_count < r_burst_len);
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // An idle block absorbs a non-restart beat without a result
    a_idle_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !r_in.restart && !r_active) |=> !o_out_valid)
        else $error("result produced outside a burst");

    // A restart beat always yields sample number one
    a_restart_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_in.restart) |=> (o_out_valid && o_out.sample_number == 8'd1))
        else $error("restart did not start at sample one");

    // The first IIR value of a burst is the scaled sample and is kept as history
    a_iir_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && r_in.restart) |=>
            (r_prev_iir == o_out.scaled_z && o_out.iir_output == o_out.scaled_z))
        else $error("IIR history not seeded by restart sample");

endmodule
